### rtl/i2c_slave_channel_register_file_assert.svh
// Assertion macros for the channel register file RTL.
`ifndef I2C_SLAVE_CHANNEL_REGISTER_FILE_ASSERT_SVH
`define I2C_SLAVE_CHANNEL_REGISTER_FILE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/i2cs_pkg.sv
// Types, codes and helpers for the I2C slave channel register file.
package i2cs_pkg;

  localparam int CHANNELS = 4;
  localparam int IDX_W    = $clog2(CHANNELS);
  localparam int RX_FRAME = 5;
  localparam int TX_FRAME = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    ACT_BUS   = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_DISABLED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_RECEIVE = 2'd0,
    PH_SEND    = 2'd1,
    PH_RESET   = 2'd2
  } phase_t;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_CODE_A   = 3'd0;
  localparam logic [2:0] REG_CODE_B   = 3'd1;
  localparam logic [2:0] REG_CODE_C   = 3'd2;
  localparam logic [2:0] REG_CODE_D   = 3'd3;
  localparam logic [2:0] REG_READ_EN  = 3'd4;
  localparam logic [2:0] REG_WRITE_EN = 3'd5;

  typedef struct packed {
    logic [CHANNELS-1:0][7:0] code;
    logic                     read_en;
    logic                     write_en;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        is_data;
    logic        bus_read;
    logic [7:0]  rx_byte;
    logic [7:0]  channel_code;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [31:0] read_value;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] rx_count;
    logic [2:0] tx_count;
  } core_state_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } lookup_t;

  // Lowest matching word wins.
  function automatic lookup_t lookup(input logic [7:0] code, input cfg_t cfg);
    lookup_t lk;
    lk = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (cfg.code[i] == code) begin
        lk.hit = 1'b1;
        lk.idx = IDX_W'(i);
      end
    end
    return lk;
  endfunction

endpackage

### rtl/i2cs_in_if.sv
// Input channel: valid/ready handshake carrying one event word.
interface i2cs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        is_data;
  logic        bus_read;
  logic [7:0]  rx_byte;
  logic [7:0]  channel_code;
  logic [31:0] write_value;

  modport source (
    output valid, action, is_data, bus_read, rx_byte, channel_code, write_value,
    input  ready
  );
  modport sink (
    input  valid, action, is_data, bus_read, rx_byte, channel_code, write_value,
    output ready
  );
endinterface

### rtl/i2cs_out_if.sv
// Result channel: valid/ready handshake carrying one result word.
interface i2cs_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [31:0] read_value;
  logic [1:0]  status;

  modport source (
    output valid, tx_valid, tx_byte, read_value, status,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_byte, read_value, status,
    output ready
  );
endinterface

### rtl/i2cs_cfg.sv
// APB-style configuration registers: channel codes and access enables.
module i2cs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cs_pkg::ADDR_W-1:0]  paddr,
  input  logic [i2cs_pkg::DATA_W-1:0]  pwdata,
  output logic [i2cs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output i2cs_pkg::cfg_t               cfg_o
);

  i2cs_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code[0]  <= 8'd16;
      cfg_r.code[1]  <= 8'd17;
      cfg_r.code[2]  <= 8'd18;
      cfg_r.code[3]  <= 8'd19;
      cfg_r.read_en  <= 1'b1;
      cfg_r.write_en <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        i2cs_pkg::REG_CODE_A:   cfg_r.code[0]  <= pwdata[7:0];
        i2cs_pkg::REG_CODE_B:   cfg_r.code[1]  <= pwdata[7:0];
        i2cs_pkg::REG_CODE_C:   cfg_r.code[2]  <= pwdata[7:0];
        i2cs_pkg::REG_CODE_D:   cfg_r.code[3]  <= pwdata[7:0];
        i2cs_pkg::REG_READ_EN:  cfg_r.read_en  <= pwdata[0];
        i2cs_pkg::REG_WRITE_EN: cfg_r.write_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      i2cs_pkg::REG_CODE_A:   prdata = {24'd0, cfg_r.code[0]};
      i2cs_pkg::REG_CODE_B:   prdata = {24'd0, cfg_r.code[1]};
      i2cs_pkg::REG_CODE_C:   prdata = {24'd0, cfg_r.code[2]};
      i2cs_pkg::REG_CODE_D:   prdata = {24'd0, cfg_r.code[3]};
      i2cs_pkg::REG_READ_EN:  prdata = {31'd0, cfg_r.read_en};
      i2cs_pkg::REG_WRITE_EN: prdata = {31'd0, cfg_r.write_en};
      default:                prdata = '0;
    endcase
  end

endmodule

### rtl/i2cs_core.sv
// Bus frame state, channel words and the one-pass result logic.
module i2cs_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire_i,
  input  i2cs_pkg::in_item_t    item_i,
  input  i2cs_pkg::cfg_t        cfg_i,
  output i2cs_pkg::result_t     res_o,
  output i2cs_pkg::core_state_t st_o
);

  i2cs_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]       rx_count_r, rx_count_nxt;
  logic [2:0]       tx_count_r, tx_count_nxt;
  logic [7:0]       sel_code_r, sel_code_nxt;
  logic [31:0]      work_r, work_nxt;
  logic [i2cs_pkg::CHANNELS-1:0][31:0] words_r;

  i2cs_pkg::lookup_t          bus_lk, loc_lk;
  logic [i2cs_pkg::IDX_W-1:0] rd_idx;
  logic [31:0]                rd_word;
  logic                       wr_en;
  logic [i2cs_pkg::IDX_W-1:0] wr_idx;
  logic [31:0]                wr_data;
  logic [1:0]                 byte_sel;

  assign bus_lk  = i2cs_pkg::lookup(sel_code_r, cfg_i);
  assign loc_lk  = i2cs_pkg::lookup(item_i.channel_code, cfg_i);
  assign rd_idx  = (item_i.action == i2cs_pkg::ACT_BUS) ? bus_lk.idx : loc_lk.idx;
  assign rd_word = words_r[rd_idx];
  assign st_o    = '{phase: phase_r, rx_count: rx_count_r, tx_count: tx_count_r};

  always_comb begin
    phase_nxt    = phase_r;
    rx_count_nxt = rx_count_r;
    tx_count_nxt = tx_count_r;
    sel_code_nxt = sel_code_r;
    work_nxt     = work_r;
    wr_en        = 1'b0;
    wr_idx       = loc_lk.idx;
    wr_data      = item_i.write_value;
    res_o        = '0;
    byte_sel     = rx_count_r[1:0] - 2'd1;

    case (item_i.action)
      i2cs_pkg::ACT_BUS: begin
        case (phase_r)
          i2cs_pkg::PH_RECEIVE: begin
            if (!item_i.is_data) begin
              if (item_i.bus_read) begin
                work_nxt       = bus_lk.hit ? rd_word : 32'd0;
                res_o.tx_valid = 1'b1;
                res_o.tx_byte  = work_nxt[7:0];
                tx_count_nxt   = 3'd1;
                phase_nxt      = i2cs_pkg::PH_SEND;
              end
            end else begin
              if (rx_count_r == 3'd0) begin
                sel_code_nxt = item_i.rx_byte;
              end else begin
                work_nxt[8*byte_sel +: 8] = item_i.rx_byte;
              end
              rx_count_nxt = rx_count_r + 3'd1;
              // Fifth data byte: commit the word and drop the frame.
              if (rx_count_nxt >= 3'(i2cs_pkg::RX_FRAME)) begin
                wr_en        = bus_lk.hit;
                wr_idx       = bus_lk.idx;
                wr_data      = work_nxt;
                phase_nxt    = i2cs_pkg::PH_RECEIVE;
                rx_count_nxt = 3'd0;
                tx_count_nxt = 3'd0;
                sel_code_nxt = 8'd0;
                work_nxt     = 32'd0;
              end
            end
          end
          i2cs_pkg::PH_SEND: begin
            res_o.tx_valid = 1'b1;
            res_o.tx_byte  = work_r[8*tx_count_r[1:0] +: 8];
            tx_count_nxt   = tx_count_r + 3'd1;
            if (tx_count_nxt >= 3'(i2cs_pkg::TX_FRAME)) begin
              phase_nxt = i2cs_pkg::PH_RESET;
            end
          end
          default: begin
            phase_nxt    = i2cs_pkg::PH_RECEIVE;
            rx_count_nxt = 3'd0;
            tx_count_nxt = 3'd0;
            sel_code_nxt = 8'd0;
            work_nxt     = 32'd0;
          end
        endcase
      end
      i2cs_pkg::ACT_WRITE: begin
        if (!cfg_i.write_en) begin
          res_o.status = i2cs_pkg::ST_DISABLED;
        end else if (loc_lk.hit) begin
          wr_en = 1'b1;
        end else begin
          res_o.status = i2cs_pkg::ST_UNKNOWN;
        end
      end
      i2cs_pkg::ACT_READ: begin
        if (!cfg_i.read_en) begin
          res_o.status = i2cs_pkg::ST_DISABLED;
        end else if (loc_lk.hit) begin
          res_o.read_value = rd_word;
        end else begin
          res_o.status = i2cs_pkg::ST_UNKNOWN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= i2cs_pkg::PH_RECEIVE;
      rx_count_r <= 3'd0;
      tx_count_r <= 3'd0;
      sel_code_r <= 8'd0;
      work_r     <= 32'd0;
      words_r    <= '0;
    end else if (fire_i) begin
      phase_r    <= phase_nxt;
      rx_count_r <= rx_count_nxt;
      tx_count_r <= tx_count_nxt;
      sel_code_r <= sel_code_nxt;
      work_r     <= work_nxt;
      if (wr_en) begin
        words_r[wr_idx] <= wr_data;
      end
    end
  end

endmodule

### rtl/i2c_slave_channel_register_file.sv
// Top level of the I2C slave channel register file.
//
// Holds four 32-bit channel words (zero after reset) and serves them over a
// byte-event channel. Each input word on in_ch is either a bus byte event
// (address or data byte from the I2C front end), a local write or a local
// read by channel code. Every input word yields exactly one result word on
// out_ch: the byte to transmit (with tx_valid), the local read value and a
// status code.
// Pipeline: a word accepted on in_ch is registered in the input register,
// processed into the result register and shown on out_ch from then on. One
// word is accepted per cycle while out_ch does not stall; the rate is set by
// the frame state update between the input register and the result register.
// When out_ch stalls, the result register holds and one more word may wait
// in the input register; after that in_ch.ready drops until out_ch drains.
// Reset (rst_n low, synchronous) clears the frame state, the channel words,
// both valid flags and restores the code and enable registers.
// Configuration: APB-style cfg_ port, registers at byte addresses 4*i; the user
// must write them only while no word is in flight, which the block does not enforce.
`include "i2c_slave_channel_register_file_assert.svh"

module i2c_slave_channel_register_file (
  input  logic                         clk,
  input  logic                         rst_n,
  i2cs_in_if.sink                      in_ch,
  i2cs_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [i2cs_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [i2cs_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [i2cs_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  i2cs_pkg::cfg_t        cfg;
  i2cs_pkg::in_item_t    in_item_r;
  logic                  in_v_r;
  i2cs_pkg::result_t     res;
  i2cs_pkg::result_t     out_res_r;
  logic                  out_v_r;
  i2cs_pkg::core_state_t core_st;
  logic                  advance;
  logic                  fire;

  i2cs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  // Result register is free when empty or being taken this cycle.
  assign advance     = !out_v_r || out_ch.ready;
  assign fire        = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= '{action:       in_ch.action,
                     is_data:      in_ch.is_data,
                     bus_read:     in_ch.bus_read,
                     rx_byte:      in_ch.rx_byte,
                     channel_code: in_ch.channel_code,
                     write_value:  in_ch.write_value};
    end
  end

  i2cs_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (fire),
    .item_i (in_item_r),
    .cfg_i  (cfg),
    .res_o  (res),
    .st_o   (core_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.tx_valid   = out_res_r.tx_valid;
  assign out_ch.tx_byte    = out_res_r.tx_byte;
  assign out_ch.read_value = out_res_r.read_value;
  assign out_ch.status     = out_res_r.status;

  `I2CS_ASSERT_IMP(a_stall_blocks_input, in_v_r && out_v_r && !out_ch.ready, !in_ch.ready, "input taken while both stages are full")
  `I2CS_ASSERT_IMP(a_send_count_range, core_st.phase == i2cs_pkg::PH_SEND, core_st.tx_count != 3'd0 && core_st.tx_count < 3'd4, "tx_count out of range in send phase")
  `I2CS_ASSERT_IMP(a_rx_count_range, 1'b1, core_st.rx_count < 3'd5, "rx_count reached frame length")
  `I2CS_ASSERT_NXT(a_reset_phase_clears, fire && in_item_r.action == i2cs_pkg::ACT_BUS && core_st.phase == i2cs_pkg::PH_RESET, core_st.phase == i2cs_pkg::PH_RECEIVE && core_st.rx_count == 3'd0, "bus event in reset phase did not clear the frame")

endmodule

### test/tb_i2c_slave_channel_register_file.sv
// Testbench for the I2C slave channel register file: predicts and checks each result word.
module tb_i2c_slave_channel_register_file;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // Shadow of the channel words and bus frame state; holds the replies still owed.
  class reg_file_shadow;
    logic [7:0]  codes[CHANNELS];
    logic        rd_en;
    logic        wr_en;
    phase_t      phase;
    logic [2:0]  rx_count;
    logic [2:0]  tx_count;
    logic [7:0]  sel_code;
    logic [31:0] work_word;
    logic [31:0] words[CHANNELS];
    result_t     pending_replies[$];
    int          n_errors;
    int          n_events;
    int          n_stored;
    int          n_bus_reads;
    int          n_local_ok;
    int          n_refused;
    int          n_unknown;

    function new();
      codes = '{8'd16, 8'd17, 8'd18, 8'd19};
      rd_en = 1'b1;
      wr_en = 1'b1;
      foreach (words[i]) words[i] = '0;
      clear_bus();
    endfunction

    function void clear_bus();
      phase     = PH_RECEIVE;
      rx_count  = '0;
      tx_count  = '0;
      sel_code  = '0;
      work_word = '0;
    endfunction

    // Lowest word index whose code matches, or -1.
    function int find_word(logic [7:0] code);
      for (int i = 0; i < CHANNELS; i++) begin
        if (codes[i] == code) return i;
      end
      return -1;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_CODE_A:   codes[0] = value[7:0];
        REG_CODE_B:   codes[1] = value[7:0];
        REG_CODE_C:   codes[2] = value[7:0];
        REG_CODE_D:   codes[3] = value[7:0];
        REG_READ_EN:  rd_en = value[0];
        REG_WRITE_EN: wr_en = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void take_event(in_item_t it);
      result_t r;
      int      k;
      int      sh;
      r = '0;
      n_events++;
      case (it.action)
        ACT_BUS: begin
          if (phase == PH_RECEIVE) begin
            if (!it.is_data) begin
              if (it.bus_read) begin
                k = find_word(sel_code);
                work_word = (k >= 0) ? words[k] : '0;
                r.tx_valid = 1'b1;
                r.tx_byte = work_word[7:0];
                tx_count = 3'd1;
                phase = PH_SEND;
                n_bus_reads++;
              end
            end else begin
              if (rx_count == 0) begin
                sel_code = it.rx_byte;
              end else begin
                sh = 8 * ((int'(rx_count) - 1) % 4);
                work_word[sh +: 8] = it.rx_byte;
              end
              rx_count = rx_count + 3'd1;
              if (rx_count >= RX_FRAME) begin
                k = find_word(sel_code);
                if (k >= 0) begin
                  words[k] = work_word;
                  n_stored++;
                end
                clear_bus();
              end
            end
          end else if (phase == PH_SEND) begin
            sh = 8 * (int'(tx_count) % 4);
            r.tx_valid = 1'b1;
            r.tx_byte = work_word[sh +: 8];
            tx_count = tx_count + 3'd1;
            if (tx_count >= TX_FRAME) phase = PH_RESET;
          end else begin
            clear_bus();
          end
        end
        ACT_WRITE: begin
          if (!wr_en) begin
            r.status = ST_DISABLED;
          end else begin
            k = find_word(it.channel_code);
            if (k >= 0) words[k] = it.write_value;
            else r.status = ST_UNKNOWN;
          end
        end
        ACT_READ: begin
          if (!rd_en) begin
            r.status = ST_DISABLED;
          end else begin
            k = find_word(it.channel_code);
            if (k >= 0) r.read_value = words[k];
            else r.status = ST_UNKNOWN;
          end
        end
        default: ;
      endcase
      if (it.action inside {ACT_WRITE, ACT_READ}) begin
        if (r.status == ST_DISABLED) n_refused++;
        else if (r.status == ST_UNKNOWN) n_unknown++;
        else n_local_ok++;
      end
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      n_errors++;
    endtask

    task check_reply(result_t got);
      result_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: %p", got));
        return;
      end
      want = pending_replies.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report_mismatch($sformatf("tx_valid got %b want %b", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report_mismatch($sformatf("tx_byte got %h want %h", got.tx_byte, want.tx_byte));
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("read_value got %h want %h", got.read_value,
                                  want.read_value));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask

    task finish_check();
      if (pending_replies.size() != 0)
        report_mismatch($sformatf("%0d result words never arrived", pending_replies.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  i2cs_in_if  in_ch();
  i2cs_out_if out_ch();

  reg_file_shadow model;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int events_sent;
  int cycle_count;

  i2c_slave_channel_register_file DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_i2c_slave_channel_register_file NOT OK");
      $finish;
    end
  end

  // Result side: a long hold-off takes priority over random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      model.check_reply(result_t'({out_ch.tx_valid, out_ch.tx_byte, out_ch.read_value,
                                   out_ch.status}));
  end

  function automatic in_item_t make_event(logic [1:0] act, logic d, logic rd, logic [7:0] b,
                                          logic [7:0] code, logic [31:0] val);
    in_item_t it;
    it.action       = act;
    it.is_data      = d;
    it.bus_read     = rd;
    it.rx_byte      = b;
    it.channel_code = code;
    it.write_value  = val;
    return it;
  endfunction

  // Bus event with random filler in the local fields.
  function automatic in_item_t bus_event(logic d, logic rd, logic [7:0] b);
    return make_event(ACT_BUS, d, rd, b, 8'($urandom), $urandom);
  endfunction

  function automatic in_item_t local_event(logic [1:0] act, logic [7:0] code,
                                           logic [31:0] val);
    return make_event(act, 1'($urandom), 1'($urandom), 8'($urandom), code, val);
  endfunction

  function automatic in_item_t any_event();
    return make_event(2'($urandom_range(3)), 1'($urandom), 1'($urandom), 8'($urandom),
                      8'($urandom), $urandom);
  endfunction

  // Mostly a configured code, sometimes any byte.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) < 80) return model.codes[$urandom_range(CHANNELS - 1)];
    return 8'($urandom);
  endfunction

  // Call at a falling edge; returns at a falling edge with valid still high.
  task automatic send_event(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.action, in_ch.is_data, in_ch.bus_read, in_ch.rx_byte, in_ch.channel_code,
     in_ch.write_value} <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model.take_event(it);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    model.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Reprogram every register once the pipeline is empty; upper bits are junk.
  task automatic configure(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                           input logic [7:0] d, input logic rd, input logic wr);
    drain();
    repeat (4) @(negedge clk);
    write_reg(REG_CODE_A, {24'($urandom), a});
    write_reg(REG_CODE_B, {24'($urandom), b});
    write_reg(REG_CODE_C, {24'($urandom), c});
    write_reg(REG_CODE_D, {24'($urandom), d});
    write_reg(REG_READ_EN, {31'($urandom), rd});
    write_reg(REG_WRITE_EN, {31'($urandom), wr});
  endtask

  task automatic bus_write_frame(input logic [7:0] code, input logic [31:0] value);
    send_event(bus_event(1'b1, 1'($urandom), code));
    for (int i = 0; i < 4; i++) send_event(bus_event(1'b1, 1'($urandom), value[8*i +: 8]));
  endtask

  // Code byte, read address, three more sends, then the event that closes the frame.
  task automatic bus_read_frame(input logic [7:0] code);
    send_event(bus_event(1'b1, 1'($urandom), code));
    send_event(bus_event(1'b0, 1'b1, 8'($urandom)));
    repeat (4) send_event(bus_event(1'($urandom), 1'($urandom), 8'($urandom)));
  endtask

  task automatic run_traffic(input int count);
    int stop_at;
    int pick;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        bus_write_frame(pick_code(), $urandom);
      end else if (pick < 55) begin
        bus_read_frame(pick_code());
      end else if (pick < 85) begin
        send_event(local_event(($urandom_range(1) != 0) ? ACT_WRITE : ACT_READ, pick_code(),
                               $urandom));
      end else if (pick < 93) begin
        // Broken frame: a few data bytes, then any bus event.
        repeat ($urandom_range(1, 4)) send_event(bus_event(1'b1, 1'($urandom), 8'($urandom)));
        send_event(bus_event(1'($urandom), 1'($urandom), 8'($urandom)));
      end else begin
        send_event(any_event());
      end
    end
  endtask

  initial begin
    model         = new();
    rst_n         = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    events_sent   = 0;
    cycle_count   = 0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_BUS;
    in_ch.is_data      = 1'b0;
    in_ch.bus_read     = 1'b0;
    in_ch.rx_byte      = '0;
    in_ch.channel_code = '0;
    in_ch.write_value  = '0;
    out_ch.ready       = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: local access extremes, unused action, one bus write and two bus reads.
    send_event(local_event(ACT_WRITE, model.codes[0], 32'hFFFF_FFFF));
    send_event(local_event(ACT_WRITE, model.codes[3], 32'hA5A5_5A5A));
    send_event(local_event(ACT_WRITE, 8'h00, 32'h1234_5678));
    send_event(local_event(ACT_READ, model.codes[0], '0));
    send_event(local_event(ACT_READ, 8'hFF, '0));
    send_event(make_event(2'b11, 1'b1, 1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    bus_write_frame(model.codes[1], 32'h8001_02FF);
    send_event(bus_event(1'b0, 1'b0, 8'hFF));
    bus_read_frame(model.codes[1]);
    bus_read_frame(8'hFF);
    send_event(local_event(ACT_READ, model.codes[1], '0));

    // Reads refused, duplicated and extreme codes; sender idles rarely, receiver often.
    configure(8'h00, 8'hFF, 8'h00, 8'h80, 1'b0, 1'b1);
    send_idle_pct = 12;
    recv_idle_pct = 71;
    run_traffic(165);

    // Writes refused; the other way round.
    configure(8'hFF, 8'hFE, 8'h01, 8'h00, 1'b1, 1'b0);
    send_idle_pct = 71;
    recv_idle_pct = 12;
    run_traffic(165);

    // Both enabled, random codes, no idling.
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Stall the result side long enough to back up the input.
    hold_left <= 80;
    run_traffic(30);
    drain();
    run_traffic(165);

    drain();
    repeat (8) @(negedge clk);
    model.finish_check();
    $display("covered %0d words: %0d bus frames stored, %0d bus reads, %0d local ok,",
             model.n_events, model.n_stored, model.n_bus_reads, model.n_local_ok);
    $display("  %0d local accesses refused and %0d with unknown code, over 4 register settings",
             model.n_refused, model.n_unknown);
    if (model.n_errors == 0) begin
      $display("tb_i2c_slave_channel_register_file OK");
    end else begin
      $display("tb_i2c_slave_channel_register_file NOT OK");
    end
    $finish;
  end

endmodule
